>>> design/two_level_writeback_cache_defines.svh
// assertion macros for the two-level write-back cache
`ifndef TWO_LEVEL_WRITEBACK_CACHE_DEFINES_SVH
`define TWO_LEVEL_WRITEBACK_CACHE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define TLWC_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tlwc assertion failed");
// next-cycle implication
`define TLWC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tlwc assertion failed");
`else
`define TLWC_ASSERT_IMPL(lbl, ante, cons)
`define TLWC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> design/tlwc_pkg.sv
// shared constants and types of the two-level write-back cache
`timescale 1ns / 1ps
`default_nettype none
package tlwc_pkg;
   localparam int unsigned LINE_BYTES = 64;
   localparam int unsigned L1_LINES   = 256;
   localparam int unsigned L2_SETS    = 256;
   localparam int unsigned MEM_BYTES  = 1048576;

   localparam int unsigned OFF_BITS  = $clog2(LINE_BYTES);
   localparam int unsigned IDX_BITS  = $clog2(L1_LINES);
   localparam int unsigned TAG_BITS  = 32 - OFF_BITS - IDX_BITS;
   localparam int unsigned WPL       = LINE_BYTES / 4;
   localparam int unsigned WOFF_BITS = $clog2(WPL);
   localparam int unsigned CNT_BITS  = WOFF_BITS + 1;
   localparam int unsigned L1D_DEPTH = L1_LINES * WPL;
   localparam int unsigned L2D_DEPTH = L2_SETS * 2 * WPL;
   localparam int unsigned MEM_WORDS = MEM_BYTES / 4;
   localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);

   // request opcodes
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   // register indexes
   localparam int unsigned CSR_IDX_BITS = 3;
   localparam logic [2:0] CSR_MEM_RD = 3'd0;
   localparam logic [2:0] CSR_MEM_WR = 3'd1;
   localparam logic [2:0] CSR_L1_RD  = 3'd2;
   localparam logic [2:0] CSR_L1_WR  = 3'd3;
   localparam logic [2:0] CSR_L2_RD  = 3'd4;
   localparam logic [2:0] CSR_L2_WR  = 3'd5;

   // tag store entry
   typedef struct packed {
      logic                valid;
      logic                dirty;
      logic [TAG_BITS-1:0] tag;
   } tag_entry_type;

   // block lies wholly inside backing memory
   function automatic logic blk_in_range(input logic [31:0] blk);
      return blk < 32'(MEM_BYTES);
   endfunction
endpackage
`default_nettype wire

>>> design/tlwc_ram.sv
// generic single-write single-read ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module tlwc_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read, old data on collision
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

>>> design/two_level_writeback_cache.sv
// two-level write-back cache: an L1 hit reads or writes one ram word, or two when the word straddles
// two ram words; an L1 miss adds L2 tag checks and block moves
// (L2 victim, L2 fill, L1 victim, L1 fill), each moved a ram word at a time over the word-wide ports
// one request in flight, result register lets the next beat in
// reset: sync; backing memory and tag stores cleared one word a cycle
`timescale 1ns / 1ps
`default_nettype none
`include "two_level_writeback_cache_defines.svh"
module two_level_writeback_cache (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_op,
   input  wire logic [31:0] req_address,
   input  wire logic [31:0] req_write_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_read_data,
   output logic             rsp_range_error,
   output logic [31:0]      rsp_elapsed,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [tlwc_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [15:0] csr_wdata
);
   localparam int unsigned IB = tlwc_pkg::IDX_BITS;
   localparam int unsigned TB = tlwc_pkg::TAG_BITS;
   localparam int unsigned WB = tlwc_pkg::WOFF_BITS;
   localparam int unsigned CB = tlwc_pkg::CNT_BITS;
   localparam int unsigned MA = tlwc_pkg::MEM_AW;
   localparam int unsigned EB = TB + 2;
   localparam int unsigned L1_N = tlwc_pkg::L1_LINES;
   localparam int unsigned L2_N = tlwc_pkg::L2_SETS;

   typedef enum logic [13:0] {
      ST_IDLE    = 14'b00000000000001,
      ST_L1CHK   = 14'b00000000000010,
      ST_L2CHK   = 14'b00000000000100,
      ST_L2WB    = 14'b00000000001000,
      ST_L2FILL  = 14'b00000000010000,
      ST_L2NEXT  = 14'b00000000100000,
      ST_L1WB    = 14'b00000001000000,
      ST_L1FILL  = 14'b00000010000000,
      ST_WORD    = 14'b00000100000000,
      ST_WORDHI  = 14'b00001000000000,
      ST_SPLIT   = 14'b00010000000000,
      ST_SPLITWR = 14'b00100000000000,
      ST_RDWAIT  = 14'b01000000000000,
      ST_DONE    = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;
   logic [IB-1:0] idx_ff, idx_in;
   logic [TB-1:0] tag_ff, tag_in, acc_tag_ff, acc_tag_in, vtag_ff, vtag_in;
   logic [TB-1:0] l2vtag_ff, l2vtag_in;
   logic [WB-1:0] woff_ff, woff_in;
   logic [1:0]    boff_ff, boff_in;
   logic          wr_ff, wr_in, second_ff, second_in, l1vict_ff, l1vict_in;
   logic          way_ff, way_in, slot_way_ff, slot_way_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic [31:0]   wdata_ff, wdata_in, rdata_ff, rdata_in, elapsed_ff, elapsed_in;
   logic          err_ff, err_in;
   logic          rsp_valid_ff, rsp_valid_in, rsp_err_ff, rsp_err_in;
   logic [31:0]   rsp_rdata_ff, rsp_rdata_in, rsp_elapsed_ff, rsp_elapsed_in;
   logic          clear_ff, clear_in;
   logic [MA-1:0] clr_addr_ff, clr_addr_in;
   logic [15:0] lat_mem_rd_ff, lat_mem_wr_ff, lat_l1_rd_ff, lat_l1_wr_ff;
   logic [15:0] lat_l2_rd_ff, lat_l2_wr_ff;

   // ram ports
   logic          l1t_we;
   logic [IB-1:0] l1t_raddr, tag_waddr;
   tlwc_pkg::tag_entry_type l1t_wdata, l1t_rd;
   logic          l2t0_we, l2t1_we;
   tlwc_pkg::tag_entry_type l2t_wdata, l2t0_rd, l2t1_rd;
   logic          lru_we, lru_wdata, lru_rd;
   logic          l1d_we;
   logic [$clog2(tlwc_pkg::L1D_DEPTH)-1:0] l1d_waddr, l1d_raddr;
   logic [31:0]   l1d_wdata, l1d_rd;
   logic          l2d_we;
   logic [$clog2(tlwc_pkg::L2D_DEPTH)-1:0] l2d_waddr, l2d_raddr;
   logic [31:0]   l2d_wdata, l2d_rd;
   logic          mem_we;
   logic [MA-1:0] mem_waddr, mem_raddr;
   logic [31:0]   mem_wdata, mem_rd;

   // helpers
   logic          accept, l1_hit, hit0, hit1, v0, v1, l2_lru, way_sel, cnt_last, cnt_wr;
   logic [WB-1:0] cnt_rw, cnt_ww, woff_nx;
   logic [29:0]   wb_word_wr, fill_word_rd;
   logic          wb_ok, fill_ok;
   logic [4:0]    bsh;
   logic [63:0]   word_pair, pair_shr, merged;

   tlwc_ram #(.WIDTH(EB), .DEPTH(L1_N)) u_l1t (
      .clock(clock), .we(l1t_we), .waddr(tag_waddr), .wdata(l1t_wdata),
      .raddr(l1t_raddr), .rdata(l1t_rd));
   tlwc_ram #(.WIDTH(EB), .DEPTH(L2_N)) u_l2t0 (
      .clock(clock), .we(l2t0_we), .waddr(tag_waddr), .wdata(l2t_wdata),
      .raddr(idx_ff), .rdata(l2t0_rd));
   tlwc_ram #(.WIDTH(EB), .DEPTH(L2_N)) u_l2t1 (
      .clock(clock), .we(l2t1_we), .waddr(tag_waddr), .wdata(l2t_wdata),
      .raddr(idx_ff), .rdata(l2t1_rd));
   tlwc_ram #(.WIDTH(1), .DEPTH(L2_N)) u_lru (
      .clock(clock), .we(lru_we), .waddr(idx_ff), .wdata(lru_wdata),
      .raddr(idx_ff), .rdata(lru_rd));
   tlwc_ram #(.WIDTH(32), .DEPTH(tlwc_pkg::L1D_DEPTH)) u_l1d (
      .clock(clock), .we(l1d_we), .waddr(l1d_waddr), .wdata(l1d_wdata),
      .raddr(l1d_raddr), .rdata(l1d_rd));
   tlwc_ram #(.WIDTH(32), .DEPTH(tlwc_pkg::L2D_DEPTH)) u_l2d (
      .clock(clock), .we(l2d_we), .waddr(l2d_waddr), .wdata(l2d_wdata),
      .raddr(l2d_raddr), .rdata(l2d_rd));
   tlwc_ram #(.WIDTH(32), .DEPTH(tlwc_pkg::MEM_WORDS)) u_mem (
      .clock(clock), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
      .raddr(mem_raddr), .rdata(mem_rd));

   // handshake outputs
   assign req_stall       = (state_ff != ST_IDLE) || clear_ff;
   assign accept          = req_valid && !req_stall;
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_rdata_ff;
   assign rsp_range_error = rsp_err_ff;
   assign rsp_elapsed     = rsp_elapsed_ff;

   // lookup and block-move helpers
   assign l1_hit     = l1t_rd.valid && (l1t_rd.tag == tag_ff);
   assign v0         = l2t0_rd.valid;
   assign v1         = l2t1_rd.valid;
   assign hit0       = v0 && (l2t0_rd.tag == acc_tag_ff);
   assign hit1       = v1 && (l2t1_rd.tag == acc_tag_ff);
   assign l2_lru     = (v0 || v1) ? lru_rd : 1'b1;
   assign way_sel    = hit0 ? 1'b0 : (hit1 ? 1'b1 : l2_lru);
   assign cnt_last   = cnt_ff == CB'(tlwc_pkg::WPL);
   assign cnt_wr     = cnt_ff != '0;
   assign cnt_rw     = cnt_ff[WB-1:0];
   assign cnt_ww     = WB'(cnt_ff - CB'(1));
   assign wb_word_wr = {l2vtag_ff, idx_ff, cnt_ww};
   assign fill_word_rd = {acc_tag_ff, idx_ff, cnt_rw};
   assign wb_ok      = tlwc_pkg::blk_in_range({l2vtag_ff, idx_ff, 6'd0});
   assign fill_ok    = tlwc_pkg::blk_in_range({acc_tag_ff, idx_ff, 6'd0});

   // word that straddles two ram words, wrapping within the line
   assign woff_nx    = woff_ff + WB'(1);
   assign bsh        = {boff_ff, 3'b000};
   assign word_pair  = {l1d_rd, rdata_ff};
   assign pair_shr   = word_pair >> bsh;
   assign merged     = (word_pair & ~(64'h0000_0000_FFFF_FFFF << bsh)) |
                       ({32'h0, wdata_ff} << bsh);

   // sequencer
   always_comb begin
      state_in = state_ff;     idx_in = idx_ff;        tag_in = tag_ff;
      acc_tag_in = acc_tag_ff; vtag_in = vtag_ff;      l2vtag_in = l2vtag_ff;
      woff_in = woff_ff;       wr_in = wr_ff;          second_in = second_ff;
      l1vict_in = l1vict_ff;   way_in = way_ff;        slot_way_in = slot_way_ff;
      cnt_in = cnt_ff;         wdata_in = wdata_ff;    rdata_in = rdata_ff;
      elapsed_in = elapsed_ff; err_in = err_ff;        boff_in = boff_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_rdata_in = rsp_rdata_ff; rsp_err_in = rsp_err_ff;
      rsp_elapsed_in = rsp_elapsed_ff;
      clear_in = clear_ff;     clr_addr_in = clr_addr_ff;
      tag_waddr = idx_ff;
      l1t_we = 1'b0;  l1t_wdata = '{valid: 1'b1, dirty: 1'b0, tag: tag_ff};
      l1t_raddr = (state_ff == ST_IDLE) ? req_address[13:6] : idx_ff;
      l2t0_we = 1'b0; l2t1_we = 1'b0;
      l2t_wdata = '{valid: 1'b1, dirty: 1'b0, tag: acc_tag_ff};
      lru_we = 1'b0;  lru_wdata = ~way_sel;
      l1d_we = 1'b0;  l1d_waddr = {idx_ff, cnt_ww}; l1d_wdata = l2d_rd;
      l1d_raddr = {idx_ff, cnt_rw};
      l2d_we = 1'b0;  l2d_waddr = {idx_ff, way_ff, cnt_ww}; l2d_wdata = l1d_rd;
      l2d_raddr = {idx_ff, way_ff, cnt_rw};
      mem_we = 1'b0;  mem_waddr = wb_word_wr[MA-1:0]; mem_wdata = l2d_rd;
      mem_raddr = fill_word_rd[MA-1:0];

      // clearing pass over backing memory and tag stores
      if (clear_ff) begin
         mem_we      = 1'b1;
         mem_waddr   = clr_addr_ff;
         mem_wdata   = '0;
         tag_waddr   = clr_addr_ff[IB-1:0];
         l1t_we      = 1'b1;
         l1t_wdata   = '0;
         l2t0_we     = 1'b1;
         l2t1_we     = 1'b1;
         l2t_wdata   = '0;
         clr_addr_in = clr_addr_ff + MA'(1);
         if (clr_addr_ff == MA'(tlwc_pkg::MEM_WORDS - 1)) begin
            clear_in = 1'b0;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in   = req_address[13:6];
               tag_in   = req_address[31:14];
               woff_in  = req_address[5:2];
               boff_in  = req_address[1:0];
               wr_in    = req_op == tlwc_pkg::OP_WRITE;
               wdata_in = req_write_data;
               rdata_in = '0;
               err_in   = 1'b0;
               if (req_op == tlwc_pkg::OP_READ || req_op == tlwc_pkg::OP_WRITE) begin
                  state_in = ST_L1CHK;
               end else begin
                  if (req_op == tlwc_pkg::OP_CLEAR) begin
                     elapsed_in = '0;
                  end
                  state_in = ST_DONE;
               end
            end
         end
         ST_L1CHK: begin
            vtag_in   = l1t_rd.tag;
            l1vict_in = l1t_rd.valid && l1t_rd.dirty;
            if (l1_hit) begin
               state_in = ST_WORD;
            end else begin
               acc_tag_in = tag_ff;
               second_in  = 1'b0;
               state_in   = ST_L2CHK;
            end
         end
         ST_L2CHK: begin
            way_in = way_sel;
            lru_we = 1'b1;
            cnt_in = '0;
            if (hit0 || hit1) begin
               state_in = ST_L2NEXT;
            end else begin
               l2vtag_in = way_sel ? l2t1_rd.tag : l2t0_rd.tag;
               if (way_sel) begin
                  l2t1_we = 1'b1;
               end else begin
                  l2t0_we = 1'b1;
               end
               if (way_sel ? (v1 && l2t1_rd.dirty) : (v0 && l2t0_rd.dirty)) begin
                  state_in = ST_L2WB;
               end else begin
                  state_in = ST_L2FILL;
               end
            end
         end
         ST_L2WB: begin
            if (!wb_ok) begin
               err_in   = 1'b1;
               state_in = ST_L2FILL;
            end else begin
               mem_we = cnt_wr;
               cnt_in = cnt_ff + CB'(1);
               if (cnt_last) begin
                  cnt_in     = '0;
                  elapsed_in = elapsed_ff + 32'(lat_mem_wr_ff);
                  state_in   = ST_L2FILL;
               end
            end
         end
         ST_L2FILL: begin
            l2d_we    = cnt_wr;
            l2d_wdata = fill_ok ? mem_rd : '0;
            cnt_in    = cnt_ff + CB'(1);
            if (cnt_last) begin
               cnt_in = '0;
               if (fill_ok) begin
                  elapsed_in = elapsed_ff + 32'(lat_mem_rd_ff);
               end else begin
                  err_in = 1'b1;
               end
               state_in = ST_L2NEXT;
            end
         end
         ST_L2NEXT: begin
            if (!second_ff) begin
               slot_way_in = way_ff;
               elapsed_in  = elapsed_ff + 32'(lat_l2_rd_ff);
               if (l1vict_ff) begin
                  acc_tag_in = vtag_ff;
                  second_in  = 1'b1;
                  state_in   = ST_L2CHK;
               end else begin
                  state_in = ST_L1FILL;
               end
            end else begin
               state_in = ST_L1WB;
            end
         end
         ST_L1WB: begin
            l2d_we = cnt_wr;
            cnt_in = cnt_ff + CB'(1);
            if (cnt_last) begin
               cnt_in    = '0;
               l2t_wdata = '{valid: 1'b1, dirty: 1'b1, tag: acc_tag_ff};
               l2t0_we   = !way_ff;
               l2t1_we   = way_ff;
               elapsed_in = elapsed_ff + 32'(lat_l2_wr_ff);
               state_in  = ST_L1FILL;
            end
         end
         ST_L1FILL: begin
            l2d_raddr = {idx_ff, slot_way_ff, cnt_rw};
            l1d_we    = cnt_wr;
            cnt_in    = cnt_ff + CB'(1);
            if (cnt_last) begin
               cnt_in    = '0;
               l1t_we    = 1'b1;
               l1t_wdata = '{valid: 1'b1,
                             dirty: slot_way_ff ? l2t1_rd.dirty : l2t0_rd.dirty,
                             tag: tag_ff};
               state_in  = ST_WORD;
            end
         end
         ST_WORD: begin
            l1d_raddr = {idx_ff, woff_ff};
            if (boff_ff != 2'd0) begin
               elapsed_in = elapsed_ff + 32'(wr_ff ? lat_l1_wr_ff : lat_l1_rd_ff);
               state_in   = ST_WORDHI;
            end else if (wr_ff) begin
               l1d_we     = 1'b1;
               l1d_waddr  = {idx_ff, woff_ff};
               l1d_wdata  = wdata_ff;
               l1t_we     = 1'b1;
               l1t_wdata  = '{valid: 1'b1, dirty: 1'b1, tag: tag_ff};
               elapsed_in = elapsed_ff + 32'(lat_l1_wr_ff);
               state_in   = ST_DONE;
            end else begin
               elapsed_in = elapsed_ff + 32'(lat_l1_rd_ff);
               state_in   = ST_RDWAIT;
            end
         end
         // low ram word arrives, fetch the next one
         ST_WORDHI: begin
            l1d_raddr = {idx_ff, woff_nx};
            rdata_in  = l1d_rd;
            state_in  = ST_SPLIT;
         end
         // both ram words on hand: extract or merge
         ST_SPLIT: begin
            if (wr_ff) begin
               l1d_we    = 1'b1;
               l1d_waddr = {idx_ff, woff_ff};
               l1d_wdata = merged[31:0];
               l1t_we    = 1'b1;
               l1t_wdata = '{valid: 1'b1, dirty: 1'b1, tag: tag_ff};
               wdata_in  = merged[63:32];
               rdata_in  = '0;
               state_in  = ST_SPLITWR;
            end else begin
               rdata_in = pair_shr[31:0];
               state_in = ST_DONE;
            end
         end
         ST_SPLITWR: begin
            l1d_we    = 1'b1;
            l1d_waddr = {idx_ff, woff_nx};
            l1d_wdata = wdata_ff;
            state_in  = ST_DONE;
         end
         ST_RDWAIT: begin
            rdata_in = l1d_rd;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_rdata_in   = rdata_ff;
               rsp_err_in     = err_ff;
               rsp_elapsed_in = elapsed_in;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         elapsed_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         clear_ff      <= 1'b1;
         clr_addr_ff   <= '0;
         lat_mem_rd_ff <= 16'd100;
         lat_mem_wr_ff <= 16'd50;
         lat_l1_rd_ff  <= 16'd1;
         lat_l1_wr_ff  <= 16'd1;
         lat_l2_rd_ff  <= 16'd10;
         lat_l2_wr_ff  <= 16'd5;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
         clear_ff     <= clear_in;
         clr_addr_ff  <= clr_addr_in;
         // configuration beat
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               tlwc_pkg::CSR_MEM_RD: lat_mem_rd_ff <= csr_wdata;
               tlwc_pkg::CSR_MEM_WR: lat_mem_wr_ff <= csr_wdata;
               tlwc_pkg::CSR_L1_RD:  lat_l1_rd_ff  <= csr_wdata;
               tlwc_pkg::CSR_L1_WR:  lat_l1_wr_ff  <= csr_wdata;
               tlwc_pkg::CSR_L2_RD:  lat_l2_rd_ff  <= csr_wdata;
               tlwc_pkg::CSR_L2_WR:  lat_l2_wr_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;      tag_ff    <= tag_in;
      acc_tag_ff  <= acc_tag_in;  vtag_ff   <= vtag_in;
      l2vtag_ff   <= l2vtag_in;   woff_ff   <= woff_in;
      boff_ff     <= boff_in;
      wr_ff       <= wr_in;       second_ff <= second_in;
      l1vict_ff   <= l1vict_in;   way_ff    <= way_in;
      slot_way_ff <= slot_way_in; wdata_ff  <= wdata_in;
      rdata_ff    <= rdata_in;    err_ff    <= err_in;
      rsp_rdata_ff   <= rsp_rdata_in;
      rsp_err_ff     <= rsp_err_in;
      rsp_elapsed_ff <= rsp_elapsed_in;
   end

   // checks
   `TLWC_ASSERT_NEXT(a_accept_leaves_idle, accept, state_ff != ST_IDLE)
   `TLWC_ASSERT_IMPL(a_clear_blocks_req, clear_ff, req_stall)
   `TLWC_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_ff <= CB'(tlwc_pkg::WPL))
   `TLWC_ASSERT_NEXT(a_done_delivers, state_ff == ST_DONE && !rsp_valid_ff, rsp_valid_ff)
endmodule
`default_nettype wire

>>> tb/testbench.sv
// self-checking testbench for the two-level write-back cache
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   import tlwc_pkg::*;

   localparam int unsigned IDLE_LIMIT = 1000000;
   localparam int unsigned DRAIN_CYCLES = 120;

   typedef struct {
      logic [31:0] read_data;
      logic        range_error;
      logic [31:0] elapsed;
   } access_result_type;

   typedef struct {
      logic [1:0]  op;
      logic [31:0] address;
      logic [31:0] write_data;
      bit          typed;
      logic [31:0] read_data;
      logic        range_error;
      logic [31:0] elapsed;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_op;
   logic [31:0] req_address;
   logic [31:0] req_write_data;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_read_data;
   logic        rsp_range_error;
   logic [31:0] rsp_elapsed;
   logic        csr_valid;
   logic        csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [15:0] csr_wdata;

   two_level_writeback_cache uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_address(req_address), .req_write_data(req_write_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_read_data(rsp_read_data),
      .rsp_range_error(rsp_range_error), .rsp_elapsed(rsp_elapsed),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // predicted cache contents
   bit [17:0] l1_tags [L1_LINES];
   bit        l1_valid [L1_LINES];
   bit        l1_dirty [L1_LINES];
   bit [7:0]  l1_bytes [L1_LINES*LINE_BYTES];
   bit [17:0] l2_tags [L2_SETS*2];
   bit        l2_valid [L2_SETS*2];
   bit        l2_dirty [L2_SETS*2];
   bit        l2_lru [L2_SETS];
   bit [7:0]  l2_bytes [L2_SETS*2*LINE_BYTES];
   bit [7:0]  main_mem [MEM_BYTES];
   bit [31:0] elapsed_time;
   bit        range_hit;
   bit [15:0] latency [6];

   access_result_type pending_results[$];
   int unsigned fail_count;
   int unsigned idle_cycles;
   int unsigned stall_tick;
   int unsigned stall_mode;
   int unsigned burst_left;
   bit          sending_done;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // backing memory block moves
   function automatic void fetch_block(input bit [31:0] blk, output bit [7:0] buffer [64]);
      if (blk >= 32'(MEM_BYTES)) begin
         range_hit = 1'b1;
         foreach (buffer[k]) buffer[k] = 8'h00;
         return;
      end
      foreach (buffer[k]) buffer[k] = main_mem[blk + k];
      elapsed_time += latency[CSR_MEM_RD];
   endfunction

   function automatic void store_block(input bit [31:0] blk, input int unsigned slot);
      if (blk >= 32'(MEM_BYTES)) begin
         range_hit = 1'b1;
         return;
      end
      for (int k = 0; k < 64; k++) main_mem[blk + k] = l2_bytes[slot*64 + k];
      elapsed_time += latency[CSR_MEM_WR];
   endfunction

   // second level lookup, allocating on a miss; returns the slot
   function automatic int unsigned l2_find(input bit [31:0] addr);
      bit [7:0]    fresh [64];
      int unsigned set_no;
      int unsigned base;
      int unsigned way;
      int unsigned slot;
      set_no = addr[13:6];
      base = set_no * 2;
      if (l2_valid[base] && l2_tags[base] == addr[31:14]) way = 0;
      else if (l2_valid[base+1] && l2_tags[base+1] == addr[31:14]) way = 1;
      else begin
         fetch_block({addr[31:6], 6'b0}, fresh);
         way = l2_lru[set_no];
         slot = base + way;
         if (l2_valid[slot] && l2_dirty[slot])
            store_block({l2_tags[slot], addr[13:6], 6'b0}, slot);
         for (int k = 0; k < 64; k++) l2_bytes[slot*64 + k] = fresh[k];
         l2_valid[slot] = 1'b1;
         l2_tags[slot] = addr[31:14];
         l2_dirty[slot] = 1'b0;
      end
      l2_lru[set_no] = ~way[0];
      return base + way;
   endfunction

   // first level line for an address, filling on a miss
   function automatic int unsigned l1_find(input bit [31:0] addr);
      bit [7:0]    fresh [64];
      int unsigned idx;
      int unsigned slot;
      idx = addr[13:6];
      if (!l1_valid[idx] || l1_tags[idx] != addr[31:14]) begin
         slot = l2_find(addr);
         for (int k = 0; k < 64; k++) fresh[k] = l2_bytes[slot*64 + k];
         elapsed_time += latency[CSR_L2_RD];
         if (l1_valid[idx] && l1_dirty[idx]) begin
            slot = l2_find({l1_tags[idx], addr[13:6], 6'b0});
            for (int k = 0; k < 64; k++) l2_bytes[slot*64 + k] = l1_bytes[idx*64 + k];
            l2_dirty[slot] = 1'b1;
            elapsed_time += latency[CSR_L2_WR];
         end
         for (int k = 0; k < 64; k++) l1_bytes[idx*64 + k] = fresh[k];
         l1_valid[idx] = 1'b1;
         l1_tags[idx] = addr[31:14];
         l1_dirty[idx] = 1'b0;
         for (int w = 0; w < 2; w++)
            if (l2_valid[idx*2 + w] && l2_tags[idx*2 + w] == addr[31:14])
               l1_dirty[idx] = l2_dirty[idx*2 + w];
      end
      return idx;
   endfunction

   function automatic access_result_type predict_access(input logic [1:0] op,
         input logic [31:0] addr, input logic [31:0] wdata);
      access_result_type res;
      int unsigned idx;
      int unsigned pos;
      range_hit = 1'b0;
      res.read_data = '0;
      if (op == OP_READ || op == OP_WRITE) begin
         idx = l1_find(addr);
         for (int k = 0; k < 4; k++) begin
            pos = idx*64 + ((addr[5:0] + k) & 63);
            if (op == OP_READ) res.read_data[8*k +: 8] = l1_bytes[pos];
            else l1_bytes[pos] = wdata[8*k +: 8];
         end
         if (op == OP_READ) elapsed_time += latency[CSR_L1_RD];
         else begin
            elapsed_time += latency[CSR_L1_WR];
            l1_dirty[idx] = 1'b1;
         end
      end else if (op == OP_CLEAR) begin
         elapsed_time = '0;
      end
      res.range_error = range_hit;
      res.elapsed = elapsed_time;
      return res;
   endfunction

   // one request beat: drive, wait for acceptance, predict
   task automatic send_request(input logic [1:0] op, input logic [31:0] addr,
         input logic [31:0] wdata, input bit typed, input access_result_type want);
      access_result_type res;
      int unsigned gap;
      req_valid <= 1'b1;
      req_op <= op;
      req_address <= addr;
      req_write_data <= wdata;
      do @(posedge clock); while (req_stall);
      res = predict_access(op, addr, wdata);
      pending_results.push_back(typed ? want : res);
      // burst and gap pacing
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      latency[idx] = value;
      @(posedge clock);
   endtask

   // drain all results, then reprogram every latency register
   task automatic program_latencies(input int unsigned style);
      logic [15:0] value;
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      for (int r = 0; r < 6; r++) begin
         case (style)
            0: begin
               value = 16'h0000;
            end
            1: begin
               value = 16'hFFFF;
            end
            2: begin
               value = 16'($urandom_range(0, 65535));
            end
            default: begin
               value = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(0, 20));
            end
         endcase
         write_register(3'(r), value);
      end
   endtask

   function automatic logic [31:0] pick_address();
      int unsigned kind;
      logic [31:0] a;
      kind = $urandom_range(0, 99);
      a = {18'($urandom_range(0, 5)), 8'($urandom_range(0, 255)), 6'($urandom_range(0, 15) * 4)};
      // concentrate on a few lines so victims and evictions recur
      if ($urandom_range(0, 2) != 0) a[13:6] = 8'($urandom_range(0, 3)) * 8'd85;
      if (kind < 5) a[31:14] = 18'($urandom_range(64, 262143));
      else if (kind < 10) a = $urandom;
      else if (kind < 14) a[5:0] = 6'($urandom_range(0, 63));
      return a;
   endfunction

   // receiver stall pattern
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 64 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
         2: begin
            rsp_stall <= ($urandom_range(0, 9) < 7);
         end
         default: begin
            rsp_stall <= stall_tick[4];
         end
      endcase
   end

   // result checking
   always @(posedge clock) begin
      access_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result beat", rsp_elapsed, 32'h0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_read_data !== want.read_data)
               report_mismatch("read_data", rsp_read_data, want.read_data);
            if (rsp_range_error !== want.range_error)
               report_mismatch("range_error", 32'(rsp_range_error), 32'(want.range_error));
            if (rsp_elapsed !== want.elapsed)
               report_mismatch("elapsed", rsp_elapsed, want.elapsed);
         end
      end
   end

   // watchdog on cycles with no beat on any channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else if (!sending_done || pending_results.size() != 0)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // stimulus
   initial begin
      directed_row_type rows [16];
      access_result_type want;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_READ;
      req_address = '0;
      req_write_data = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      fail_count = 0;
      idle_cycles = 0;
      stall_tick = 0;
      stall_mode = 0;
      burst_left = 0;
      sending_done = 1'b0;
      elapsed_time = '0;
      latency = '{16'd100, 16'd50, 16'd1, 16'd1, 16'd10, 16'd5};
      foreach (l2_lru[s]) l2_lru[s] = 1'b1;

      rows = '{
         '{OP_READ,  32'h0000_0000, 32'h0,         1, 32'h0, 1'b0, 32'd111},
         '{OP_WRITE, 32'h0000_0000, 32'hFFFF_FFFF, 1, 32'h0, 1'b0, 32'd112},
         '{OP_CLEAR, 32'h0000_0000, 32'h0,         1, 32'h0, 1'b0, 32'd0},
         '{OP_READ,  32'hFFFF_FFFC, 32'h0,         1, 32'h0, 1'b1, 32'd11},
         '{OP_NONE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0, 1'b0, 32'd11},
         '{OP_READ,  32'h0000_0000, 32'h0,         0, 32'h0, 1'b0, 32'd0},
         '{OP_WRITE, 32'h0000_4000, 32'h1234_5678, 0, 32'h0, 1'b0, 32'd0},
         '{OP_WRITE, 32'h0000_8004, 32'h8765_4321, 0, 32'h0, 1'b0, 32'd0},
         '{OP_READ,  32'h0000_0000, 32'h0,         0, 32'h0, 1'b0, 32'd0},
         '{OP_READ,  32'h0000_C000, 32'h0,         0, 32'h0, 1'b0, 32'd0},
         '{OP_WRITE, 32'h0000_003D, 32'hA5A5_A5A5, 0, 32'h0, 1'b0, 32'd0},
         '{OP_READ,  32'h0000_003E, 32'h0,         0, 32'h0, 1'b0, 32'd0},
         '{OP_WRITE, 32'hFFFF_FFC0, 32'h5A5A_5A5A, 0, 32'h0, 1'b0, 32'd0},
         '{OP_READ,  32'hFFFB_FFFC, 32'h0,         0, 32'h0, 1'b0, 32'd0},
         '{OP_WRITE, 32'h000F_FFFC, 32'hDEAD_BEEF, 0, 32'h0, 1'b0, 32'd0},
         '{OP_READ,  32'h0000_4000, 32'h0,         0, 32'h0, 1'b0, 32'd0}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows at reset latencies
      foreach (rows[i]) begin
         want.read_data = rows[i].read_data;
         want.range_error = rows[i].range_error;
         want.elapsed = rows[i].elapsed;
         send_request(rows[i].op, rows[i].address, rows[i].write_data, rows[i].typed, want);
      end

      // random phases, each under its own latency setting
      for (int phase = 0; phase < 4; phase++) begin
         program_latencies(phase);
         for (int n = 0; n < 260; n++) begin
            int unsigned pick;
            logic [1:0] op;
            pick = $urandom_range(0, 99);
            op = (pick < 46) ? OP_READ : (pick < 92) ? OP_WRITE : (pick < 97) ? OP_CLEAR : OP_NONE;
            send_request(op, pick_address(), $urandom, 1'b0, want);
         end
      end
      req_valid <= 1'b0;
      sending_done = 1'b1;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
`default_nettype wire
